@@ hdl/bdll_pkg.sv @@
// ----------------------------------------------------------------------------
// bdll_pkg
// Shared types and constants for the bounded doubly linked list engine:
// request and response payloads, action and status codes.
// ----------------------------------------------------------------------------
package bdll_pkg;

  localparam int CAPACITY_DEF    = 32;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int ITEM_W          = 32;

  typedef enum logic [1:0] {
    ACT_APPEND   = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_DUMP_FWD = 2'd2,
    ACT_DUMP_BWD = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    action_t                   action;
    logic signed [ITEM_W-1:0]  value;
  } in_req_t;

  typedef struct packed {
    logic signed [ITEM_W-1:0]  item_value;
    status_t                   status;
    logic                      last_of_run;
  } out_rsp_t;

endpackage

@@ hdl/bounded_doubly_linked_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// bounded_doubly_linked_list_engine_core
// Ordered list of up to CAPACITY values kept as linked slots in on-chip memory.
// ----------------------------------------------------------------------------
// Each request runs one action: append at the tail, remove the first match
// from the head, or dump the list forward or backward. Slot values and the
// forward and backward links live in three synchronous memories with a
// registered read; head, tail, entry count and the free-slot map are
// flip-flops. One request is worked at a time. Remove and dump time is set
// by the list walk: one memory read per linked slot, the next address
// coming straight from the link just read; any request also waits while
// the result side stalls. A new request is taken while the last result
// still waits in the output register. There is no clearing pass after
// reset: slot memory contents are only used while linked into the list.
// ----------------------------------------------------------------------------
module bounded_doubly_linked_list_engine_core #(
  parameter int CAPACITY    = bdll_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bdll_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bdll_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output bdll_pkg::out_rsp_t out_rsp
);
  import bdll_pkg::*;

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // slot index
  localparam int CW = $clog2(CAPACITY + 1);                    // entry count

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  // control state
  state_t                  state_r, state_nxt;
  logic [SW-1:0]           head_r, head_nxt;
  logic [SW-1:0]           tail_r, tail_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CAPACITY-1:0]     free_r, free_nxt;
  logic [CW-1:0]           rem_r, rem_nxt;
  logic                    out_valid_r;

  // request context
  logic [VALUE_WIDTH-1:0]  key_r, key_nxt;
  logic                    bwd_r, bwd_nxt;
  logic                    dump_r, dump_nxt;
  status_t                 resp_r, resp_nxt;
  logic [SW-1:0]           cur_r;
  out_rsp_t                out_rsp_r;

  // slot memories
  logic [VALUE_WIDTH-1:0]  mem_val  [CAPACITY];
  logic [SW-1:0]           mem_next [CAPACITY];
  logic [SW-1:0]           mem_prev [CAPACITY];
  logic [VALUE_WIDTH-1:0]  rd_val_r;
  logic [SW-1:0]           rd_next_r;
  logic [SW-1:0]           rd_prev_r;

  logic [SW-1:0]           rd_addr;
  logic                    val_we, next_we, prev_we;
  logic [SW-1:0]           val_wa, next_wa, prev_wa;
  logic [VALUE_WIDTH-1:0]  val_wd;
  logic [SW-1:0]           next_wd, prev_wd;

  logic                    out_free;
  logic                    out_load;
  out_rsp_t                out_load_rsp;
  logic [SW-1:0]           alloc;
  logic [VALUE_WIDTH-1:0]  in_val;

  // Sign-extend or truncate the request value to the stored width.
  assign in_val = VALUE_WIDTH'(in_req.value);

  // Lowest free slot; only used when the list is not full.
  always_comb begin
    alloc = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        alloc = SW'(i);
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cnt_nxt      = cnt_r;
    free_nxt     = free_r;
    rem_nxt      = rem_r;
    key_nxt      = key_r;
    bwd_nxt      = bwd_r;
    dump_nxt     = dump_r;
    resp_nxt     = resp_r;
    rd_addr      = cur_r;      // hold the current slot unless advancing
    val_we       = 1'b0;
    next_we      = 1'b0;
    prev_we      = 1'b0;
    val_wa       = alloc;
    prev_wa      = alloc;
    next_wa      = tail_r;
    val_wd       = in_val;
    next_wd      = alloc;
    prev_wd      = tail_r;
    out_load     = 1'b0;
    out_load_rsp = '0;

    unique case (state_r)
      ST_IDLE: begin
        // Start the walk read at the proper end as the request comes in.
        rd_addr = (in_req.action == ACT_DUMP_BWD) ? tail_r : head_r;
        if (in_valid) begin
          key_nxt  = in_val;
          bwd_nxt  = (in_req.action == ACT_DUMP_BWD);
          dump_nxt = (in_req.action == ACT_DUMP_FWD) || (in_req.action == ACT_DUMP_BWD);
          rem_nxt  = cnt_r;
          unique case (in_req.action)
            ACT_APPEND: begin
              state_nxt = ST_RESP;
              if (cnt_r == CW'(CAPACITY)) begin
                resp_nxt = STAT_FULL;
              end else begin
                // Store the value, link back to the old tail, and forward
                // from the old tail when the list was not empty.
                resp_nxt = STAT_OK;
                val_we   = 1'b1;
                prev_we  = 1'b1;
                prev_wd  = (cnt_r == '0) ? '0 : tail_r;
                next_we  = (cnt_r != '0);
                if (cnt_r == '0) begin
                  head_nxt = alloc;
                end
                tail_nxt = alloc;
                cnt_nxt  = cnt_r + CW'(1);
                free_nxt = free_r & ~(CAPACITY'(1) << alloc);
              end
            end
            ACT_REMOVE: begin
              if (cnt_r == '0) begin
                resp_nxt  = STAT_NOT_FOUND;
                state_nxt = ST_RESP;
              end else begin
                state_nxt = ST_WALK;
              end
            end
            default: begin
              if (cnt_r == '0) begin
                resp_nxt  = STAT_EMPTY;
                state_nxt = ST_RESP;
              end else begin
                state_nxt = ST_WALK;
              end
            end
          endcase
        end
      end

      ST_WALK: begin
        if (dump_r) begin
          // Emit the slot just read; stall on a full output register.
          if (out_free) begin
            out_load                 = 1'b1;
            out_load_rsp.item_value  = ITEM_W'(rd_val_r);
            out_load_rsp.status      = STAT_OK;
            out_load_rsp.last_of_run = (rem_r == CW'(1));
            rd_addr                  = bwd_r ? rd_prev_r : rd_next_r;
            rem_nxt                  = rem_r - CW'(1);
            if (rem_r == CW'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end else if (rd_val_r == key_r) begin
          // Unlink the matching slot and give it back to the free map.
          resp_nxt  = STAT_OK;
          state_nxt = ST_RESP;
          if (cur_r == head_r) begin
            head_nxt = rd_next_r;
          end else begin
            next_we = 1'b1;
            next_wa = rd_prev_r;
            next_wd = rd_next_r;
          end
          if (cur_r == tail_r) begin
            tail_nxt = rd_prev_r;
          end else begin
            prev_we = 1'b1;
            prev_wa = rd_next_r;
            prev_wd = rd_prev_r;
          end
          if (cnt_r == CW'(1)) begin
            head_nxt = '0;
            tail_nxt = '0;
          end
          cnt_nxt  = cnt_r - CW'(1);
          free_nxt = free_r | (CAPACITY'(1) << cur_r);
        end else if (rem_r == CW'(1)) begin
          resp_nxt  = STAT_NOT_FOUND;
          state_nxt = ST_RESP;
        end else begin
          rd_addr = rd_next_r;
          rem_nxt = rem_r - CW'(1);
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_load                 = 1'b1;
          out_load_rsp.item_value  = '0;
          out_load_rsp.status      = resp_r;
          out_load_rsp.last_of_run = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Slot memories: one write and one registered read each per cycle.
  always_ff @(posedge clk) begin
    if (val_we) begin
      mem_val[val_wa] <= val_wd;
    end
    if (next_we) begin
      mem_next[next_wa] <= next_wd;
    end
    if (prev_we) begin
      mem_prev[prev_wa] <= prev_wd;
    end
    rd_val_r  <= mem_val[rd_addr];
    rd_next_r <= mem_next[rd_addr];
    rd_prev_r <= mem_prev[rd_addr];
    cur_r     <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      free_r      <= '1;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      free_r  <= free_nxt;
      rem_r   <= rem_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request context and output register need no reset.
  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    bwd_r  <= bwd_nxt;
    dump_r <= dump_nxt;
    resp_r <= resp_nxt;
    if (out_load) begin
      out_rsp_r <= out_load_rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Entry count never passes the slot budget.
  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // Entry count agrees with the number of allocated slots.
  a_cnt_free : assert property (@(posedge clk) disable iff (!rst_n)
    (CAPACITY - $countones(free_r)) == int'(cnt_r))
    else $error("entry count and free map disagree");

  // An empty list parks head and tail at slot zero.
  a_empty_ends : assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (head_r == '0) && (tail_r == '0))
    else $error("empty list with stray head or tail");

  // A taken request always leaves idle.
  a_busy_after_req : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("request accepted without starting work");

endmodule

@@ dv/bdll_sb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bdll_sb_pkg
// Scoreboard for the linked list engine: keeps an ordered shadow copy of the
// list, predicts the responses of each accepted request and checks them.
// ----------------------------------------------------------------------------
package bdll_sb_pkg;

  import bdll_pkg::*;

  localparam int REPORT_LIMIT = 10;

  class list_scoreboard;

    logic signed [ITEM_W-1:0] entries[$];
    out_rsp_t                 pending_rsps[$];
    int                       error_count;
    int                       rsp_count;

    function new();
      error_count = 0;
      rsp_count   = 0;
    endfunction

    function int pending_count();
      return pending_rsps.size();
    endfunction

    function void push_rsp(logic signed [ITEM_W-1:0] val, status_t stat, logic last);
      out_rsp_t rsp;
      rsp.item_value  = val;
      rsp.status      = stat;
      rsp.last_of_run = last;
      pending_rsps.push_back(rsp);
    endfunction

    // Update the shadow list for one accepted request and queue its responses.
    function void note_request(in_req_t req);
      int n;
      int idx;
      int i;
      n   = entries.size();
      idx = -1;
      case (req.action)
        ACT_APPEND: begin
          if (n >= CAPACITY_DEF) begin
            push_rsp('0, STAT_FULL, 1'b1);
          end else begin
            entries.push_back(req.value);
            push_rsp('0, STAT_OK, 1'b1);
          end
        end
        ACT_REMOVE: begin
          for (i = 0; i < n; i++) begin
            if (entries[i] === req.value) begin
              idx = i;
              break;
            end
          end
          if (idx < 0) begin
            push_rsp('0, STAT_NOT_FOUND, 1'b1);
          end else begin
            entries.delete(idx);
            push_rsp('0, STAT_OK, 1'b1);
          end
        end
        ACT_DUMP_FWD, ACT_DUMP_BWD: begin
          if (n == 0) begin
            push_rsp('0, STAT_EMPTY, 1'b1);
          end else begin
            for (i = 0; i < n; i++) begin
              push_rsp((req.action == ACT_DUMP_FWD) ? entries[i] : entries[n-1-i],
                       STAT_OK, (i == n - 1));
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_response(out_rsp_t rsp);
      out_rsp_t want;
      rsp_count++;
      if (pending_rsps.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("response %0d: none expected, got value=%0d status=%0d last=%0b",
                   rsp_count, rsp.item_value, rsp.status, rsp.last_of_run);
        return;
      end
      want = pending_rsps.pop_front();
      if (rsp.item_value !== want.item_value || rsp.status !== want.status ||
          rsp.last_of_run !== want.last_of_run) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("response %0d: expected value=%0d status=%0d last=%0b, got value=%0d status=%0d last=%0b",
                   rsp_count, want.item_value, want.status, want.last_of_run,
                   rsp.item_value, rsp.status, rsp.last_of_run);
      end
    endfunction

  endclass

endpackage

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bounded_doubly_linked_list_engine_core. Directed
// requests hit the empty, single-entry, duplicate, head, tail, middle and
// miss cases; random episodes then fill the list to full, drain and mix it
// under three handshake pressure phases, with every response checked in order.
// ----------------------------------------------------------------------------
module tb;

  import bdll_pkg::*;
  import bdll_sb_pkg::*;

  localparam int CLK_HIGH_NS    = 6;
  localparam int CLK_LOW_NS     = 6;
  localparam int RESET_CYCLES   = 12;
  localparam int REQUEST_TARGET = 160;
  localparam int SETTLE_CYCLES  = 40;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int LIST_CAP       = CAPACITY_DEF;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_rsp;

  int          send_idle_pct = 25;
  int          recv_idle_pct = 54;
  int          sent_count    = 0;
  int unsigned cycle_count   = 0;

  list_scoreboard sb;

  bounded_doubly_linked_list_engine_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  always begin
    #CLK_HIGH_NS clk = 1'b1;
    #CLK_LOW_NS  clk = 1'b0;
  end

  // Hard stop in case the block hangs or drops a response.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[bounded_doubly_linked_list_engine_core] ERROR");
      $finish;
    end
  end

  // Response side: check each accepted response, then pick the next ready
  // at random. Outputs are read before this edge's updates land.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_response(out_rsp);
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Drive one request and hold it until accepted. Valid is left high on
  // return so that a back-to-back request keeps it high without a gap.
  task automatic issue_request(action_t act, logic signed [ITEM_W-1:0] val);
    in_req_t req;
    int      phase;
    phase = sent_count * 3 / REQUEST_TARGET;
    // Receiver-heavy idling first, then sender-heavy, then full rate.
    case (phase)
      0: begin
        send_idle_pct = 25;
        recv_idle_pct = 54;
      end
      1: begin
        send_idle_pct = 54;
        recv_idle_pct = 25;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
    req.action = act;
    req.value  = val;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    sent_count++;
  endtask

  // Corner values, entries already in the list (to make duplicates), or
  // fully random words.
  function automatic logic signed [ITEM_W-1:0] pick_value();
    logic signed [ITEM_W-1:0] val;
    case ($urandom_range(0, 4))
      0: begin
        case ($urandom_range(0, 4))
          0:       val = 32'sh8000_0000;
          1:       val = 32'sh7FFF_FFFF;
          2:       val = '0;
          3:       val = -1;
          default: val = 1;
        endcase
      end
      1: begin
        if (sb.entries.size() > 0)
          val = sb.entries[$urandom_range(0, sb.entries.size() - 1)];
        else
          val = $urandom;
      end
      default: val = $urandom;
    endcase
    return val;
  endfunction

  // Removal mostly hits a listed value, sometimes misses.
  function automatic logic signed [ITEM_W-1:0] pick_remove_value();
    if (sb.entries.size() > 0 && $urandom_range(0, 9) < 7)
      return sb.entries[$urandom_range(0, sb.entries.size() - 1)];
    return pick_value();
  endfunction

  function automatic action_t pick_dump();
    return $urandom_range(0, 1) ? ACT_DUMP_BWD : ACT_DUMP_FWD;
  endfunction

  // Append up to capacity, push a few more against the full list, dump it.
  task automatic fill_list();
    while (sb.entries.size() < LIST_CAP)
      issue_request(ACT_APPEND, pick_value());
    repeat ($urandom_range(1, 3)) issue_request(ACT_APPEND, $urandom);
    issue_request(pick_dump(), $urandom);
  endtask

  // Remove every entry in random order, then poke the empty list.
  task automatic drain_list();
    while (sb.entries.size() > 0)
      issue_request(ACT_REMOVE, sb.entries[$urandom_range(0, sb.entries.size() - 1)]);
    issue_request(ACT_REMOVE, $urandom);
    issue_request(pick_dump(), $urandom);
  endtask

  task automatic issue_mixed();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: issue_request(ACT_APPEND, pick_value());
      4, 5, 6:    issue_request(ACT_REMOVE, pick_remove_value());
      default:    issue_request(pick_dump(), $urandom);
    endcase
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list: both dumps report empty, remove reports not found.
    issue_request(ACT_DUMP_FWD, $urandom);
    issue_request(ACT_DUMP_BWD, $urandom);
    issue_request(ACT_REMOVE, 32'sd5);
    // Single entry in and out again.
    issue_request(ACT_APPEND, 32'sh7FFF_FFFF);
    issue_request(ACT_REMOVE, 32'sh7FFF_FFFF);
    issue_request(ACT_DUMP_FWD, $urandom);
    // Extreme values, with a duplicate of the head at the tail.
    issue_request(ACT_APPEND, 32'sh8000_0000);
    issue_request(ACT_APPEND, 32'sh0000_0000);
    issue_request(ACT_APPEND, -32'sd1);
    issue_request(ACT_APPEND, 32'sh5555_5555);
    issue_request(ACT_APPEND, 32'shAAAA_AAAA);
    issue_request(ACT_APPEND, 32'sh8000_0000);
    issue_request(ACT_DUMP_FWD, $urandom);
    issue_request(ACT_DUMP_BWD, $urandom);
    // Head first (first match of the duplicate), then the tail, a middle
    // entry and a miss.
    issue_request(ACT_REMOVE, 32'sh8000_0000);
    issue_request(ACT_REMOVE, 32'sh8000_0000);
    issue_request(ACT_REMOVE, -32'sd1);
    issue_request(ACT_REMOVE, 32'sd12345);
    issue_request(ACT_DUMP_FWD, $urandom);
    issue_request(ACT_DUMP_BWD, $urandom);

    // Random episodes, starting with one run up to the full list.
    fill_list();
    while (sent_count < REQUEST_TARGET) begin
      case ($urandom_range(0, 9))
        0: begin
          if (sent_count < REQUEST_TARGET - 40)
            fill_list();
          else
            issue_mixed();
        end
        1, 2: begin
          if (sent_count < REQUEST_TARGET - 40)
            drain_list();
          else
            issue_mixed();
        end
        default: repeat ($urandom_range(4, 8)) issue_mixed();
      endcase
    end
    in_valid <= 1'b0;

    // Wait for every response, then give the block time to show extras.
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.error_count == 0 && sb.pending_count() == 0)
      $display("[bounded_doubly_linked_list_engine_core] OK");
    else
      $display("[bounded_doubly_linked_list_engine_core] ERROR");
    $finish;
  end

endmodule
